[rtl/savgol_smoothing_filter_core_assert.svh]
// Assertion macros for the smoothing filter core.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SAVGOL_SMOOTHING_FILTER_CORE_ASSERT_SVH
`define SAVGOL_SMOOTHING_FILTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SGF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sgf_pkg.sv]
// Shared types and constants of the smoothing filter core.
// No dependencies.
`timescale 1ns / 1ps
package sgf_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int HALF        = 5;
  localparam int TAPS        = 2 * HALF + 1;
  localparam int NUM_WEIGHTS = HALF + 1;
  localparam int WEIGHT_BITS = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_W       = SAMPLE_BITS + 14;
  localparam int DEN_W       = 14;
  localparam int DVD_W       = NUM_W + 1;
  localparam int DSR_W       = DEN_W + 1;

  localparam logic [DVD_W-1:0] SAT_HI = DVD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    final_sample;
  } in_t;

  typedef struct packed {
    sample_t value;
    logic    smoothed;
    logic    series_end;
  } out_t;

  function automatic weight_t weight_reset(input logic [CFG_IDX_W-1:0] idx);
    weight_t w;
    unique case (idx)
      3'd0:    w = -10'sd36;
      3'd1:    w = 10'sd9;
      3'd2:    w = 10'sd44;
      3'd3:    w = 10'sd69;
      3'd4:    w = 10'sd84;
      default: w = 10'sd89;
    endcase
    return w;
  endfunction
endpackage

[rtl/sgf_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sgf_pkg for operand widths.
`timescale 1ns / 1ps
module sgf_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sgf_pkg::DVD_W-1:0] dividend_i,
  input  logic [sgf_pkg::DSR_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [sgf_pkg::DVD_W-1:0] quotient_o
);
  import sgf_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W:0]   trial;
  logic             fits;
  logic [DSR_W:0]   diff;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    fits  = trial >= {1'b0, dsr_q};
    diff  = trial - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        // shift dividend out at the top, quotient bits in at the bottom
        rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

[rtl/savgol_smoothing_filter_core.sv]
// 11-point symmetric smoothing filter on a series of signed samples.
// Path: a raw pass-through result is registered from S_RAW, entered on its transaction;
// a smoothed result goes through the bit-serial weight MAC, setup, divide and emit.
// Throughput: one transaction at a time; input stalls until the core is idle, once its
// result is registered; at series end, held samples flush one per cycle unless stalled.
// Reset (async, active low) clears control and the delay line and restores the weights.
`timescale 1ns / 1ps
module savgol_smoothing_filter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sgf_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sgf_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgf_pkg::WEIGHT_BITS-1:0] cfg_data_i
);
  import sgf_pkg::*;

  `include "savgol_smoothing_filter_core_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_MAC, S_SETUP, S_DIV, S_EMIT, S_FLUSH
  } state_e;

  localparam int IDX_W = $clog2(TAPS);
  localparam int K_W   = $clog2(NUM_WEIGHTS);
  localparam int J_W   = $clog2(WEIGHT_BITS);

  state_e                  state_q;
  sample_t                 dl_q [TAPS];
  logic [IDX_W-1:0]        pos_q;
  logic [IDX_W-1:0]        p_q;
  logic                    fin_q;
  weight_t                 w_q [NUM_WEIGHTS];
  logic [K_W-1:0]          k_q;
  logic [J_W-1:0]          j_q;
  logic signed [NUM_W-1:0] num_q;
  logic signed [DEN_W-1:0] den_q;
  logic signed [NUM_W-1:0] term_q;
  weight_t                 wsh_q;
  logic                    neg_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic                          accept;
  logic                          out_free;
  logic signed [SAMPLE_BITS:0]   pairsum [NUM_WEIGHTS];
  logic signed [NUM_W-1:0]       cur_term;
  logic                          cur_bit;
  weight_t                       cur_w;
  logic signed [NUM_W-1:0]       addend;
  logic [NUM_W-1:0]              an;
  logic [DEN_W-1:0]              ad;
  logic [DVD_W-1:0]              dividend;
  logic [DSR_W-1:0]              divisor;
  logic                          div_start;
  logic                          div_done;
  logic [DVD_W-1:0]              quo;
  sample_t                       sat_val;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int k = 0; k < HALF; k++) begin
      pairsum[k] = (SAMPLE_BITS + 1)'(dl_q[k]) + (SAMPLE_BITS + 1)'(dl_q[TAPS - 1 - k]);
    end
    pairsum[HALF] = (SAMPLE_BITS + 1)'(dl_q[HALF]);
  end

  // first bit of a tap starts from the pair sum, later bits from the shifted term
  always_comb begin
    cur_w    = (j_q == '0) ? w_q[k_q] : wsh_q;
    cur_term = (j_q == '0) ? NUM_W'(pairsum[k_q]) : term_q;
    cur_bit  = cur_w[0];
    if (!cur_bit) begin
      addend = '0;
    end else if (j_q == J_W'(WEIGHT_BITS - 1)) begin
      addend = -cur_term;
    end else begin
      addend = cur_term;
    end
  end

  always_comb begin
    an        = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
    ad        = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    dividend  = {an, 1'b0} + DVD_W'(ad);
    divisor   = {ad, 1'b0};
    div_start = (state_q == S_SETUP) && (den_q != '0);
  end

  sgf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    if (neg_q) begin
      sat_val = (quo > SAT_HI + 1'b1) ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                      : SAMPLE_BITS'(~quo + 1'b1);
    end else begin
      sat_val = (quo > SAT_HI) ? {1'b0, {(SAMPLE_BITS - 1){1'b1}}} : quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      for (int i = 0; i < TAPS; i++) begin
        dl_q[i] <= '0;
      end
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        w_q[i] <= weight_reset(CFG_IDX_W'(i));
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NUM_WEIGHTS)) begin
        w_q[cfg_idx_i[K_W-1:0]] <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            for (int i = TAPS - 1; i > 0; i--) begin
              dl_q[i] <= dl_q[i-1];
            end
            dl_q[0] <= in_data_i.sample;
            fin_q   <= in_data_i.final_sample;
            p_q     <= pos_q;
            if (in_data_i.final_sample) begin
              pos_q <= '0;
            end else if (pos_q < IDX_W'(2 * HALF)) begin
              pos_q <= pos_q + 1'b1;
            end
            if (pos_q < IDX_W'(HALF)) begin
              state_q <= S_RAW;
            end else if (pos_q >= IDX_W'(2 * HALF)) begin
              state_q <= S_MAC;
              k_q     <= '0;
              j_q     <= '0;
              num_q   <= '0;
              den_q   <= '0;
            end else if (in_data_i.final_sample) begin
              state_q <= S_FLUSH;
              idx_q   <= pos_q - IDX_W'(HALF);
            end
          end
        end
        S_RAW: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.value      <= dl_q[0];
            out_q.smoothed   <= 1'b0;
            out_q.series_end <= fin_q;
            state_q          <= S_IDLE;
          end
        end
        S_MAC: begin
          num_q  <= num_q + addend;
          term_q <= cur_term <<< 1;
          wsh_q  <= cur_w >>> 1;
          if (j_q == '0) begin
            den_q <= (k_q == K_W'(HALF)) ? den_q + DEN_W'(w_q[k_q])
                                         : den_q + (DEN_W'(w_q[k_q]) <<< 1);
          end
          if (j_q == J_W'(WEIGHT_BITS - 1)) begin
            j_q <= '0;
            k_q <= k_q + 1'b1;
            if (k_q == K_W'(HALF)) begin
              state_q <= S_SETUP;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_SETUP: begin
          neg_q <= num_q[NUM_W-1] != den_q[DEN_W-1];
          if (den_q == '0) begin
            // zero weight sum: pass the centre sample raw
            if (out_free) begin
              out_valid_q      <= 1'b1;
              out_q.value      <= dl_q[HALF];
              out_q.smoothed   <= 1'b0;
              out_q.series_end <= 1'b0;
              state_q          <= fin_q ? S_FLUSH : S_IDLE;
              idx_q            <= IDX_W'(HALF - 1);
            end
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.value      <= sat_val;
            out_q.smoothed   <= 1'b1;
            out_q.series_end <= 1'b0;
            state_q          <= fin_q ? S_FLUSH : S_IDLE;
            idx_q            <= IDX_W'(HALF - 1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.value      <= dl_q[idx_q];
            out_q.smoothed   <= 1'b0;
            out_q.series_end <= idx_q == '0;
            idx_q            <= idx_q - 1'b1;
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SGF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output changed")
  `SGF_ASSERT_IMP(a_div_nonzero, div_start, den_q != '0, "divide started on zero weight sum")
  `SGF_ASSERT_IMP(a_div_done_state, div_done, state_q == S_DIV, "divide finished out of turn")
  `SGF_ASSERT_IMP(a_flush_fin, state_q == S_FLUSH, fin_q, "flush without final sample")
endmodule
